// File: src/fdd_pkg.sv
package fdd_pkg;

  localparam logic [7:0] FLAG_A = 8'hC0;
  localparam logic [7:0] FLAG_B = 8'h7E;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 2 * BYTE_W;

  typedef enum logic [1:0] {
    MODE_FLAG_C0 = 2'd0,
    MODE_FLAG_7E = 2'd1,
    MODE_LENGTH  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_FLAG    = 4'b0010,
    PH_LENLO   = 4'b0100,
    PH_LENDATA = 4'b1000
  } phase_t;

endpackage

// File: src/frame_deframer_delim_or_length_core.sv
// Byte-stream deframer: cuts a raw byte stream into frames.
// Channels: input bytes on in_valid/in_ready/in_byte; result bytes on
// out_valid/out_ready/out_byte with frame_end set on the last byte of a frame;
// frame_mode is written through cfg_valid/cfg_ready (always ready).
// Modes: 0 frames delimited by flag 0xC0, 1 by flag 0x7E (opening and closing
// flags are passed on, bytes outside a frame are dropped), 2 a two-byte
// big-endian length header followed by that many bytes, 3 drops everything.
// An accepted byte is held in the input register, and its result is loaded
// into the output register when the input register advances, which waits
// while the output register holds a stalled beat. Header and dropped bytes
// give no result beat.
// Throughput: one byte per cycle, sustained, while out_ready is high; the
// limit is the single phase/length update done per input register advance.
// Reset clears the mode to 0 and restarts framing (hunting / length high).
// Any mode write restarts framing too; write it only while the block is idle.
// When the receiver stalls, the output register holds its beat and the input
// register holds one more byte; in_ready then drops until out_ready returns.
module frame_deframer_delim_or_length_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       frame_mode,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fdd_pkg::BYTE_W-1:0]       in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fdd_pkg::BYTE_W-1:0]       out_byte,
  output logic                             frame_end
);

  fdd_pkg::mode_t                mode;
  fdd_pkg::phase_t               phase;
  fdd_pkg::phase_t               phase_next;
  logic [fdd_pkg::LEN_W-1:0]     bytes_left;
  logic [fdd_pkg::LEN_W-1:0]     bytes_left_next;
  logic [fdd_pkg::BYTE_W-1:0]    length_high;
  logic [fdd_pkg::BYTE_W-1:0]    length_high_next;

  logic                          s1_valid;
  logic [fdd_pkg::BYTE_W-1:0]    s1_byte;
  logic                          s1_advance;

  logic                          emit;
  logic                          emit_end;
  logic [fdd_pkg::BYTE_W-1:0]    flag;
  logic [fdd_pkg::LEN_W-1:0]     left_dec;
  logic [fdd_pkg::LEN_W-1:0]     header_len;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  assign flag       = (mode == fdd_pkg::MODE_FLAG_C0) ? fdd_pkg::FLAG_A : fdd_pkg::FLAG_B;
  assign left_dec   = bytes_left - fdd_pkg::LEN_W'(1);
  assign header_len = {length_high, s1_byte};

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    length_high_next = length_high;
    emit             = 1'b0;
    emit_end         = 1'b0;
    unique case (mode) inside
      fdd_pkg::MODE_FLAG_C0, fdd_pkg::MODE_FLAG_7E: begin
        if (phase == fdd_pkg::PH_FLAG) begin
          emit = 1'b1;
          if (s1_byte == flag) begin
            emit_end   = 1'b1;
            phase_next = fdd_pkg::PH_START;
          end
        end else if (s1_byte == flag) begin
          emit       = 1'b1;
          phase_next = fdd_pkg::PH_FLAG;
        end else begin
          phase_next = fdd_pkg::PH_START;
        end
      end
      fdd_pkg::MODE_LENGTH: begin
        if (phase == fdd_pkg::PH_LENLO) begin
          bytes_left_next = header_len;
          phase_next      = (header_len == '0) ? fdd_pkg::PH_START : fdd_pkg::PH_LENDATA;
        end else if (phase == fdd_pkg::PH_LENDATA) begin
          emit            = 1'b1;
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            emit_end   = 1'b1;
            phase_next = fdd_pkg::PH_START;
          end
        end else begin
          length_high_next = s1_byte;
          phase_next       = fdd_pkg::PH_LENLO;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= fdd_pkg::MODE_FLAG_C0;
      phase       <= fdd_pkg::PH_START;
      bytes_left  <= '0;
      length_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mode        <= fdd_pkg::mode_t'(frame_mode);
      phase       <= fdd_pkg::PH_START;
      bytes_left  <= '0;
      length_high <= '0;
    end else if (s1_advance) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      length_high <= length_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      out_byte  <= s1_byte;
      frame_end <= emit_end;
    end
  end

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == fdd_pkg::PH_LENDATA) |-> (bytes_left != '0))
    else $error("length frame open with no bytes left");

  a_close_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end && (mode == fdd_pkg::MODE_FLAG_C0)) |-> (out_byte == fdd_pkg::FLAG_A))
    else $error("frame closed on a byte that is not the flag");

  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && s1_valid) |-> !in_ready)
    else $error("input taken while both registers are full");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && emit_end && !cfg_valid) |=> (phase == fdd_pkg::PH_START))
    else $error("framing did not restart after a frame end");

endmodule
